// ===== sv/bpa_pkg.sv =====
// bpa_pkg: shared types, codes and constants of the buddy page allocator
// no dependencies
package bpa_pkg;

    localparam int LEVELS_DEF = 10;

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_USED   = 2'd1;
    localparam logic [1:0] ST_SPLIT  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_SIZE  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam int REQ_W = 16;
    localparam int OFF_W = 10;
    localparam int PAGES_W = 11;

    // command word passed from the front end to the tree engine
    typedef struct packed {
        logic [1:0]       opcode;
        logic             too_large;
        logic [4:0]       size_log;
        logic [OFF_W-1:0] offset;
    } bpa_cmd_t;

endpackage

// ===== sv/bpa_ram.sv =====
// bpa_ram: generic single port ram with registered read
// no dependencies
module bpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== sv/bpa_front.sv =====
// bpa_front: accepts request words, rounds sizes and queues commands
// depends on bpa_pkg
module bpa_front #(
    parameter int LEVELS = bpa_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [bpa_pkg::REQ_W-1:0]     request_pages,
    input  logic [bpa_pkg::OFF_W-1:0]     block_offset,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output bpa_pkg::bpa_cmd_t             cmd
);
    import bpa_pkg::*;

    localparam int QD = 2;

    bpa_cmd_t  q_reg [QD];
    logic      wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    bpa_cmd_t  c;
    logic [4:0] lg;
    logic [REQ_W:0] m;

    // ceil log2 of the request, zero counting as one
    always_comb
    begin
        m = {1'b0, request_pages} - 17'd1;
        lg = 5'd0;
        for (int i = 0; i < REQ_W; i++)
            if (request_pages > 16'd1 && m[i])
                lg = 5'(i + 1);
        c.opcode = opcode;
        c.size_log = lg;
        c.too_large = ({27'd0, lg} > 32'(LEVELS));
        c.offset = block_offset;
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rp_reg];

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            wp_next = ~wp_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (cmd_valid && cmd_ready)
        begin
            rp_next = ~rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            q_reg[wp_reg] <= c;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && !(in_valid && in_ready)) |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("queue count mismatch");
endmodule

// ===== sv/bpa_engine.sv =====
// bpa_engine: tree walk sequencer over the node state memory
// depends on bpa_pkg and bpa_ram
module bpa_engine #(
    parameter int LEVELS = bpa_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  bpa_pkg::bpa_cmd_t             cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [1:0]                    status,
    output logic [bpa_pkg::OFF_W-1:0]     result_offset,
    output logic [bpa_pkg::PAGES_W-1:0]   block_pages
);
    import bpa_pkg::*;

    localparam int NODES = (2 << LEVELS) - 1;
    localparam int AW = LEVELS + 1;
    localparam int LW = $clog2(LEVELS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_ARD    = 5'd2;
    localparam logic [4:0] S_AEV    = 5'd3;
    localparam logic [4:0] S_SPL1   = 5'd4;
    localparam logic [4:0] S_SPL2   = 5'd5;
    localparam logic [4:0] S_UP     = 5'd6;
    localparam logic [4:0] S_FURD   = 5'd7;
    localparam logic [4:0] S_FUEV   = 5'd8;
    localparam logic [4:0] S_FRD    = 5'd9;
    localparam logic [4:0] S_FEV    = 5'd10;
    localparam logic [4:0] S_RURD   = 5'd11;
    localparam logic [4:0] S_RUEV   = 5'd12;
    localparam logic [4:0] S_RSET   = 5'd13;
    localparam logic [4:0] S_RARD   = 5'd14;
    localparam logic [4:0] S_RAEV   = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;
    localparam logic [4:0] S_SETU   = 5'd17;

    logic [4:0]     st_reg, st_next;
    logic [AW-1:0]  idx_reg, idx_next, clr_reg, clr_next;
    logic [LW-1:0]  lvl_reg, lvl_next;
    logic [AW-1:0]  left_reg, left_next;
    bpa_cmd_t       cmd_reg;
    logic [1:0]     stat_reg, stat_next;
    logic [OFF_W-1:0]   roff_reg, roff_next;
    logic [PAGES_W-1:0] pg_reg, pg_next;

    logic           we;
    logic [AW-1:0]  addr;
    logic [1:0]     wdata, rdata;

    bpa_ram #(.WIDTH(2), .DEPTH(NODES)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [AW-1:0] buddy, parent, offset_ext, half, node_off;
    logic [LW-1:0] tgt;
    logic [AW:0]   one_lvl;

    always_comb
    begin
        buddy = idx_reg[0] ? idx_reg + 1'b1 : idx_reg - 1'b1;
        parent = AW'((idx_reg + 1'b1) >> 1) - 1'b1;
        offset_ext = AW'(cmd_reg.offset);
        tgt = LW'(LEVELS - int'(cmd_reg.size_log));
        half = AW'((AW+1)'(1) << (LEVELS - 1 - int'(lvl_reg)));
        one_lvl = (AW+1)'(1) << lvl_reg;
        node_off = AW'(((AW+1)'(idx_reg) + 1'b1 - one_lvl) << (LEVELS - int'(lvl_reg)));
    end

    always_comb
    begin
        st_next = st_reg;
        idx_next = idx_reg;
        clr_next = clr_reg;
        lvl_next = lvl_reg;
        left_next = left_reg;
        stat_next = stat_reg;
        roff_next = roff_reg;
        pg_next = pg_reg;
        we = 1'b0;
        addr = idx_reg;
        wdata = ST_UNUSED;
        cmd_ready = 1'b0;
        case (st_reg)
            S_CLR:
            begin
                we = 1'b1;
                addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(NODES - 1))
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                idx_next = '0;
                lvl_next = '0;
                left_next = '0;
                roff_next = '0;
                pg_next = '0;
                if (cmd_valid)
                begin
                    stat_next = STATUS_INVALID;
                    if (cmd.opcode == OP_ALLOC)
                    begin
                        stat_next = STATUS_NOSPACE;
                        st_next = cmd.too_large ? S_OUT : S_ARD;
                    end
                    else if (cmd.opcode == OP_FREE || cmd.opcode == OP_SIZE)
                        st_next = (32'(cmd.offset) >= (32'd1 << LEVELS)) ? S_OUT : S_FRD;
                    else
                        st_next = S_OUT;
                end
            end
            S_ARD: st_next = S_AEV;
            S_AEV:
            begin
                if (lvl_reg == tgt)
                begin
                    if (rdata == ST_UNUSED)
                        st_next = S_SETU;
                    else
                        st_next = S_UP;
                end
                else if (rdata == ST_USED || rdata == ST_FULL)
                    st_next = S_UP;
                else if (rdata == ST_UNUSED)
                begin
                    we = 1'b1;
                    wdata = ST_SPLIT;
                    st_next = S_SPL1;
                end
                else
                begin
                    idx_next = {idx_reg[AW-2:0], 1'b1};
                    lvl_next = lvl_reg + 1'b1;
                    st_next = S_ARD;
                end
            end
            S_SPL1:
            begin
                we = 1'b1;
                addr = {idx_reg[AW-2:0], 1'b1};
                st_next = S_SPL2;
            end
            S_SPL2:
            begin
                we = 1'b1;
                addr = {idx_reg[AW-2:0], 1'b0} + AW'(2);
                idx_next = {idx_reg[AW-2:0], 1'b1};
                lvl_next = lvl_reg + 1'b1;
                st_next = S_ARD;
            end
            S_UP:
            begin
                if (idx_reg[0])
                begin
                    idx_next = idx_reg + 1'b1;
                    st_next = S_ARD;
                end
                else if (idx_reg == '0)
                    st_next = S_OUT;
                else
                begin
                    idx_next = parent;
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            S_SETU:
            begin
                we = 1'b1;
                wdata = ST_USED;
                stat_next = STATUS_OK;
                roff_next = OFF_W'(node_off);
                pg_next = PAGES_W'(1) << cmd_reg.size_log;
                st_next = (idx_reg == '0) ? S_OUT : S_FURD;
            end
            S_FURD:
            begin
                addr = buddy;
                st_next = S_FUEV;
            end
            S_FUEV:
            begin
                if (rdata == ST_USED || rdata == ST_FULL)
                begin
                    we = 1'b1;
                    addr = parent;
                    wdata = ST_FULL;
                    idx_next = parent;
                    st_next = (parent == '0) ? S_OUT : S_FURD;
                end
                else
                    st_next = S_OUT;
            end
            S_FRD: st_next = S_FEV;
            S_FEV:
            begin
                if (rdata == ST_USED)
                begin
                    if (offset_ext != left_reg)
                        st_next = S_OUT;
                    else if (cmd_reg.opcode == OP_SIZE)
                    begin
                        stat_next = STATUS_OK;
                        pg_next = PAGES_W'((AW+1)'(1) << (LEVELS - int'(lvl_reg)));
                        st_next = S_OUT;
                    end
                    else
                        st_next = (idx_reg == '0) ? S_RSET : S_RURD;
                end
                else if (rdata == ST_UNUSED || int'(lvl_reg) >= LEVELS)
                    st_next = S_OUT;
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                    if (offset_ext < left_reg + half)
                        idx_next = {idx_reg[AW-2:0], 1'b1};
                    else
                    begin
                        left_next = left_reg + half;
                        idx_next = {idx_reg[AW-2:0], 1'b0} + AW'(2);
                    end
                    st_next = S_FRD;
                end
            end
            S_RURD:
            begin
                addr = buddy;
                st_next = S_RUEV;
            end
            S_RUEV:
            begin
                if (rdata != ST_UNUSED)
                    st_next = S_RSET;
                else
                begin
                    idx_next = parent;
                    st_next = (parent == '0) ? S_RSET : S_RURD;
                end
            end
            S_RSET:
            begin
                we = 1'b1;
                wdata = ST_UNUSED;
                stat_next = STATUS_OK;
                if (idx_reg == '0)
                    st_next = S_OUT;
                else
                begin
                    idx_next = parent;
                    st_next = S_RARD;
                end
            end
            S_RARD: st_next = S_RAEV;
            S_RAEV:
            begin
                if (rdata == ST_FULL)
                begin
                    we = 1'b1;
                    wdata = ST_SPLIT;
                    if (idx_reg == '0)
                        st_next = S_OUT;
                    else
                    begin
                        idx_next = parent;
                        st_next = S_RARD;
                    end
                end
                else
                    st_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                    st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR;
            clr_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lvl_reg <= lvl_next;
        left_reg <= left_next;
        stat_reg <= stat_next;
        roff_reg <= roff_next;
        pg_reg <= pg_next;
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
    end

    assign res_valid = (st_reg == S_OUT);
    assign status = stat_reg;
    assign result_offset = roff_reg;
    assign block_pages = pg_reg;

    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(stat_reg))
        else $error("result lost before taken");
    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> st_reg == S_IDLE)
        else $error("command taken while busy");
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && stat_reg == STATUS_NOSPACE) |-> pg_reg == '0)
        else $error("failed allocate with nonzero size");
endmodule

// ===== sv/buddy_page_allocator.sv =====
// buddy_page_allocator: top level of the buddy page allocator
// depends on bpa_pkg, bpa_front, bpa_engine
// Binary buddy allocator over 2^LEVELS pages. After reset all 2^(LEVELS+1)-1 nodes
// of the node state memory are cleared before the first word is taken. The front end
// rounds each request and queues up to two words; the tree engine then walks the
// single port node memory. Each node read is a read state followed by an evaluate
// state, a split writes the two children in states of their own, and marking or
// clearing a block is one write. The engine takes a new word only after the result
// of the last one is taken, and a failing allocate backtracks over split nodes. The
// single port memory sets the pace.
module buddy_page_allocator #(
    parameter int LEVELS = bpa_pkg::LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // opcode, request_pages, block_offset, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status, result_offset, block_pages, zero pad
);
    import bpa_pkg::*;

    bpa_cmd_t cmd;
    logic     cmd_valid, cmd_ready;
    logic [1:0] status;
    logic [OFF_W-1:0] result_offset;
    logic [PAGES_W-1:0] block_pages;

    bpa_front #(.LEVELS(LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .opcode(s_axis_tdata[1:0]), .request_pages(s_axis_tdata[17:2]),
        .block_offset(s_axis_tdata[27:18]),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    bpa_engine #(.LEVELS(LEVELS)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .status(status), .result_offset(result_offset), .block_pages(block_pages)
    );

    assign m_axis_tdata = {1'b0, block_pages, result_offset, status};
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for buddy_page_allocator, with its own tree model,
// directed and random allocate/free/query traffic and random idling on both streams
// depends on bpa_pkg and the buddy_page_allocator rtl
module tb_top;
    import bpa_pkg::*;

    localparam int LEVELS = 10;
    localparam int NODES = (2 << LEVELS) - 1;
    localparam int NPAGES = 1 << LEVELS;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [10:0] pages;
        logic [9:0]  offset;
        logic [1:0]  status;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // opcode, request_pages, block_offset, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status, result_offset, block_pages, zero pad

    logic [1:0] tree [NODES];
    outcome_t   pending_outcomes[$];
    int         live_blocks[$];
    int         mismatches;
    int         idle_cycles;
    bit         src_idle_en;
    bit         sink_idle_en;

    buddy_page_allocator #(.LEVELS(LEVELS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int buddy_idx(int idx);
        return (idx & 1) ? idx + 1 : idx - 1;
    endfunction

    function automatic int parent_idx(int idx);
        return (idx + 1) / 2 - 1;
    endfunction

    function automatic bit tree_alloc(int size, output int off);
        int len;
        int idx;
        int lvl;
        int b;
        len = NPAGES;
        idx = 0;
        lvl = 0;
        off = 0;
        if (size > len)
            return 0;
        forever
        begin
            if (size == len)
            begin
                if (tree[idx] == ST_UNUSED)
                begin
                    tree[idx] = ST_USED;
                    off = (idx + 1 - (1 << lvl)) << (LEVELS - lvl);
                    forever
                    begin
                        b = buddy_idx(idx);
                        if (b > 0 && (tree[b] == ST_USED || tree[b] == ST_FULL))
                        begin
                            idx = parent_idx(idx);
                            tree[idx] = ST_FULL;
                        end
                        else
                            return 1;
                    end
                end
            end
            else if (tree[idx] != ST_USED && tree[idx] != ST_FULL)
            begin
                if (tree[idx] == ST_UNUSED)
                begin
                    tree[idx] = ST_SPLIT;
                    tree[2*idx+1] = ST_UNUSED;
                    tree[2*idx+2] = ST_UNUSED;
                end
                idx = 2*idx + 1;
                len = len >> 1;
                lvl++;
                continue;
            end
            if (idx & 1)
            begin
                idx++;
                continue;
            end
            forever
            begin
                lvl--;
                len = len << 1;
                idx = parent_idx(idx);
                if (idx < 0)
                    return 0;
                if (idx & 1)
                begin
                    idx++;
                    break;
                end
            end
        end
    endfunction

    function automatic bit tree_find(int off, output int node, output int len);
        int left;
        int lvl;
        int idx;
        left = 0;
        len = NPAGES;
        lvl = 0;
        idx = 0;
        node = 0;
        if (off >= NPAGES)
            return 0;
        forever
        begin
            if (tree[idx] == ST_USED)
            begin
                node = idx;
                return off == left;
            end
            if (tree[idx] == ST_UNUSED || lvl >= LEVELS)
                return 0;
            len = len >> 1;
            lvl++;
            if (off < left + len)
                idx = 2*idx + 1;
            else
            begin
                left += len;
                idx = 2*idx + 2;
            end
        end
    endfunction

    function automatic void tree_release(int idx);
        int b;
        forever
        begin
            b = buddy_idx(idx);
            if (b < 0 || tree[b] != ST_UNUSED)
            begin
                tree[idx] = ST_UNUSED;
                idx = parent_idx(idx);
                while (idx >= 0 && tree[idx] == ST_FULL)
                begin
                    tree[idx] = ST_SPLIT;
                    idx = parent_idx(idx);
                end
                return;
            end
            idx = parent_idx(idx);
        end
    endfunction

    function automatic outcome_t predict_outcome(logic [1:0] op, int req, int off);
        outcome_t o;
        int size;
        int got;
        int node;
        int len;
        o = '{status: STATUS_INVALID, offset: '0, pages: '0};
        if (op == OP_ALLOC)
        begin
            size = 1;
            while (size < req)
                size = size << 1;
            if (tree_alloc(size, got))
            begin
                o.status = STATUS_OK;
                o.offset = 10'(got);
                o.pages = 11'(size);
                live_blocks.push_back(got);
            end
            else
                o.status = STATUS_NOSPACE;
        end
        else if (op == OP_FREE)
        begin
            if (tree_find(off, node, len))
            begin
                tree_release(node);
                o.status = STATUS_OK;
                foreach (live_blocks[i])
                    if (live_blocks[i] == off)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
            end
        end
        else if (op == OP_SIZE)
        begin
            if (tree_find(off, node, len))
            begin
                o.status = STATUS_OK;
                o.pages = 11'(len);
            end
        end
        return o;
    endfunction

    task automatic send_word(logic [1:0] op, logic [15:0] req, logic [9:0] off);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {4'b0, off, req, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_outcomes.push_back(predict_outcome(op, int'(req), int'(off)));
        @(negedge clk);
    endtask

    function automatic int pick_live_offset();
        if (live_blocks.size() == 0)
            return $urandom_range(0, NPAGES - 1);
        return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    endfunction

    task automatic test_directed();
        send_word(OP_SIZE, 16'h0, 10'd0);
        send_word(OP_FREE, 16'h0, 10'd0);
        send_word(OP_ALLOC, 16'hFFFF, 10'h3FF);
        send_word(OP_ALLOC, 16'd1025, 10'd0);
        send_word(OP_ALLOC, 16'd1024, 10'd0);
        send_word(OP_ALLOC, 16'd0, 10'd0);
        send_word(OP_SIZE, 16'h0, 10'd0);
        send_word(OP_SIZE, 16'h0, 10'd1);
        send_word(OP_FREE, 16'h0, 10'd0);
        send_word(OP_ALLOC, 16'd0, 10'h3FF);
        send_word(OP_ALLOC, 16'd3, 10'd0);
        send_word(OP_ALLOC, 16'd512, 10'd0);
        send_word(OP_ALLOC, 16'd1, 10'd0);
        send_word(OP_SIZE, 16'h0, 10'd4);
        send_word(OP_FREE, 16'h0, 10'd5);
        send_word(OP_FREE, 16'h0, 10'd4);
        send_word(OP_FREE, 16'h0, 10'd512);
        send_word(OP_ALLOC, 16'd300, 10'd0);
        send_word(2'd3, 16'hFFFF, 10'h3FF);
        send_word(OP_FREE, 16'h0, 10'd0);
        send_word(OP_FREE, 16'h0, 10'd1);
        send_word(OP_FREE, 16'h0, 10'd512);
        send_word(OP_SIZE, 16'h0, 10'h3FF);
    endtask

    task automatic test_random(int count);
        int k;
        logic [1:0]  op;
        logic [15:0] req;
        logic [9:0]  off;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    op = OP_ALLOC;
                    if ($urandom_range(0, 19) == 0)
                        req = 16'($urandom);
                    else
                        req = 16'($urandom_range(0, 1 << $urandom_range(0, 7)));
                end
                4, 5, 6:
                begin
                    op = OP_FREE;
                    req = 16'($urandom);
                end
                7, 8:
                begin
                    op = OP_SIZE;
                    req = 16'($urandom);
                end
                default:
                begin
                    op = 2'($urandom_range(0, 3));
                    req = 16'($urandom);
                end
            endcase
            off = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'(pick_live_offset());
            send_word(op, req, off);
        end
    endtask

    task automatic test_drain();
        while (live_blocks.size() > 0)
            send_word(OP_FREE, 16'($urandom), 10'(live_blocks[0]));
        send_word(OP_ALLOC, 16'd1024, 10'd0);
        send_word(OP_FREE, 16'd0, 10'd0);
    endtask

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[22:0];
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", got);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st %0d off %0d pg %0d, got st %0d off %0d pg %0d",
                                 want.status, want.offset, want.pages,
                                 got.status, got.offset, got.pages);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int stall;
        if (sink_idle_en && m_axis_tready && $urandom_range(0, 3) == 0)
        begin
            stall = $urandom_range(1, 10);
            m_axis_tready <= 1'b0;
            repeat (stall) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NODES; i++)
            tree[i] = ST_UNUSED;
        src_idle_en = 1;
        sink_idle_en = 1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(600);
        src_idle_en = 0;
        sink_idle_en = 0;
        test_random(120);
        test_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== buddy_page_allocator.f =====
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_front.sv
sv/bpa_engine.sv
sv/buddy_page_allocator.sv
dv/tb_top.sv
